[src/amwp_pkg.sv]
// Shared types and constants for the windowed acceleration magnitude peak unit.
// No dependencies; every other source file imports this package.
`timescale 1ns / 1ps

package amwp_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int NUM_LANES    = 3;
    localparam int SQUARE_WIDTH = 32;
    localparam int ROOT_WIDTH   = 16;
    localparam int COUNT_WIDTH  = 12;
    localparam int LEN_WIDTH    = 13;
    localparam int CMP_WIDTH    = (COUNT_WIDTH + 1 > LEN_WIDTH) ? COUNT_WIDTH + 1 : LEN_WIDTH;

    localparam int STEP_COUNT   = SQUARE_WIDTH / 2;
    localparam int STEP_WIDTH   = $clog2(STEP_COUNT);

    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;

    localparam logic [LEN_WIDTH-1:0] WINDOW_LEN_RESET = LEN_WIDTH'(250);
    localparam logic [ROOT_WIDTH-1:0] ROOT_MAX = ROOT_WIDTH'(56755);

    // Register index, taken from paddr[2].
    localparam logic REG_WINDOW_LEN = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_UPDATE,
        ST_ROOT,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic                    emit;
        logic [SQUARE_WIDTH-1:0] peak;
    } merge_status_t;

    typedef struct packed {
        logic                  busy;
        logic [ROOT_WIDTH-1:0] root;
    } root_status_t;

endpackage

[src/accel_magnitude_window_peak_unit.sv]
// Top level of the windowed acceleration magnitude peak unit.
// Depends on amwp_pkg, amwp_square_lane, amwp_merge and amwp_isqrt.
`timescale 1ns / 1ps

// How to use this block
// The slave stream takes one three-axis sample per transfer: s_tdata carries
// accel_x, accel_y and accel_z as signed 16-bit raw counts. Three square
// lanes work on the axes side by side, a merging stage adds the squares and
// keeps the largest squared magnitude of the current window. When the
// window_len-th sample of a window arrives, a 16-step square root unit turns
// the peak into raw counts, and the result leaves on the master stream as one
// 16-bit transfer; the window then starts again from zero.
// A sample that does not close a window passes the square, sum and update
// states and returns to idle before the next transfer is taken. A sample
// that closes a window goes through the lanes and merge, then the square
// root state (16 steps and the load of the output register), then idle.
// The output register keeps the result while the receiver stalls; the next
// sample is taken meanwhile. Only when another result is finished before the
// previous one has been taken does the block wait, with s_tready low.
// window_len is written over the APB port at address 0 while the block is
// idle. A length of 0 acts as 1 and lengths above 4096 act as 4096.
// Reset (aresetn low, synchronous) empties the window, drops any result
// not yet taken and sets window_len to 250.

module accel_magnitude_window_peak_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // s_tdata, lowest bit up: accel_x[15:0], accel_y[31:16], accel_z[47:32]
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [3*amwp_pkg::SAMPLE_WIDTH-1:0]    s_tdata,
    // m_tdata, lowest bit up: peak_magnitude[15:0]
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [amwp_pkg::ROOT_WIDTH-1:0]        m_tdata,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [amwp_pkg::APB_ADDR_WIDTH-1:0]    paddr,
    input  logic [amwp_pkg::APB_DATA_WIDTH-1:0]    pwdata,
    output logic [amwp_pkg::APB_DATA_WIDTH-1:0]    prdata,
    output logic                                   pready
);
    import amwp_pkg::*;

    state_t state_reg, state_next;

    logic [LEN_WIDTH-1:0]  window_len_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [ROOT_WIDTH-1:0] m_tdata_reg;

    logic s_accept;
    logic lane_load, sum_en, update_en, root_start, out_load, out_free;

    logic [NUM_LANES-1:0][SQUARE_WIDTH-1:0] lane_square;
    merge_status_t merge_st;
    root_status_t  root_st;

    // Configuration port. The register index sits at paddr[2]; byte offsets
    // below it are ignored.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= WINDOW_LEN_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_LEN) begin
            window_len_reg <= pwdata[LEN_WIDTH-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_WINDOW_LEN) begin
            prdata = APB_DATA_WIDTH'(window_len_reg);
        end else begin
            prdata = '0;
        end
    end

    // Each lane squares one axis of the sample.
    generate
        for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
            amwp_square_lane u_lane (
                .aclk   (aclk),
                .load   (lane_load),
                .sample (s_tdata[i*SAMPLE_WIDTH +: SAMPLE_WIDTH]),
                .square (lane_square[i])
            );
        end
    endgenerate

    amwp_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sum_en      (sum_en),
        .update_en   (update_en),
        .window_len  (window_len_reg),
        .lane_square (lane_square),
        .status      (merge_st)
    );

    amwp_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .operand (merge_st.peak),
        .status  (root_st)
    );

    assign s_accept = s_tvalid && s_tready;
    // The output register can take a new result if it is empty or being drained.
    assign out_free = !m_tvalid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                state_next = ST_SUM;
            end
            ST_SUM: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = merge_st.emit ? ST_ROOT : ST_IDLE;
            end
            ST_ROOT: begin
                if (!root_st.busy) begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb begin
        s_tready   = 1'b0;
        lane_load  = 1'b0;
        sum_en     = 1'b0;
        update_en  = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                lane_load = s_tvalid;
            end
            ST_SQUARE: begin
                sum_en = 1'b1;
            end
            ST_UPDATE: begin
                update_en  = 1'b1;
                root_start = merge_st.emit;
            end
            ST_ROOT: begin
                out_load = !root_st.busy && out_free;
            end
            ST_HOLD: begin
                out_load = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Output register.
    always_comb begin
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= root_st.root;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The square root unit only runs while the controller waits for it.
    a_root_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        root_st.busy |-> state_reg == ST_ROOT)
        else $error("square root unit busy outside the root state");

    // A completed window always starts the square root unit.
    a_emit_starts_root: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPDATE && merge_st.emit |=> root_st.busy)
        else $error("window completed without starting the square root");

    // No new sample is taken while a result is still being formed.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> !root_st.busy && state_reg != ST_HOLD)
        else $error("sample taken while a result is pending");

    // The root of a sum of three 16-bit squares never exceeds its bound.
    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> root_st.root <= ROOT_MAX)
        else $error("square root result out of range");

endmodule

[src/amwp_square_lane.sv]
// One lane: squares a signed raw axis count and holds the product.
// Depends on amwp_pkg.
`timescale 1ns / 1ps

module amwp_square_lane (
    input  logic                                      aclk,
    input  logic                                      load,
    input  logic signed [amwp_pkg::SAMPLE_WIDTH-1:0]  sample,
    output logic        [amwp_pkg::SQUARE_WIDTH-1:0]  square
);
    import amwp_pkg::*;

    logic signed [SQUARE_WIDTH-1:0] product;
    logic        [SQUARE_WIDTH-1:0] square_reg;

    // A signed square is never negative and fits in 31 bits.
    assign product = SQUARE_WIDTH'(sample) * SQUARE_WIDTH'(sample);

    always_ff @(posedge aclk) begin
        if (load) begin
            square_reg <= unsigned'(product);
        end
    end

    assign square = square_reg;

endmodule

[src/amwp_merge.sv]
// Merging stage: sums the lane squares, tracks the window peak and sample count.
// Depends on amwp_pkg.
`timescale 1ns / 1ps

module amwp_merge (
    input  logic                                               aclk,
    input  logic                                               aresetn,
    input  logic                                               sum_en,
    input  logic                                               update_en,
    input  logic [amwp_pkg::LEN_WIDTH-1:0]                     window_len,
    input  logic [amwp_pkg::NUM_LANES-1:0][amwp_pkg::SQUARE_WIDTH-1:0] lane_square,
    output amwp_pkg::merge_status_t                            status
);
    import amwp_pkg::*;

    localparam logic [CMP_WIDTH-1:0] COUNT_MAX = CMP_WIDTH'(1) << COUNT_WIDTH;

    logic [SQUARE_WIDTH-1:0] sum_reg;
    logic [SQUARE_WIDTH-1:0] peak_reg, peak_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic [SQUARE_WIDTH-1:0] new_peak;
    logic [CMP_WIDTH-1:0]    len_wide, len_eff, count_inc;
    logic                    emit;

    // The sum of three squares of 16-bit counts stays below 2^32.
    always_ff @(posedge aclk) begin
        if (sum_en) begin
            sum_reg <= lane_square[0] + lane_square[1] + lane_square[2];
        end
    end

    always_comb begin
        len_wide = CMP_WIDTH'(window_len);
        if (len_wide == '0) begin
            len_eff = CMP_WIDTH'(1);
        end else if (len_wide > COUNT_MAX) begin
            len_eff = COUNT_MAX;
        end else begin
            len_eff = len_wide;
        end
        new_peak  = (sum_reg > peak_reg) ? sum_reg : peak_reg;
        count_inc = CMP_WIDTH'(count_reg) + CMP_WIDTH'(1);
        emit      = (count_inc >= len_eff);
        if (emit) begin
            peak_next  = '0;
            count_next = '0;
        end else begin
            peak_next  = new_peak;
            count_next = count_inc[COUNT_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg  <= '0;
            count_reg <= '0;
        end else if (update_en) begin
            peak_reg  <= peak_next;
            count_reg <= count_next;
        end
    end

    assign status.emit = emit;
    assign status.peak = new_peak;

    // A finished window always leaves the count and peak cleared.
    a_clear_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        update_en && emit |=> count_reg == '0 && peak_reg == '0)
        else $error("window state not cleared after emit");

    // Within a window the peak never shrinks.
    a_peak_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        update_en && !emit |=> peak_reg >= $past(peak_reg))
        else $error("peak decreased within a window");

    // Only an update moves the count.
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !update_en |=> $stable(count_reg))
        else $error("sample count changed without an update");

endmodule

[src/amwp_isqrt.sv]
// Iterative integer square root, one result bit per cycle.
// Depends on amwp_pkg.
`timescale 1ns / 1ps

module amwp_isqrt (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [amwp_pkg::SQUARE_WIDTH-1:0]  operand,
    output amwp_pkg::root_status_t             status
);
    import amwp_pkg::*;

    localparam logic [SQUARE_WIDTH-1:0] BIT_INIT = SQUARE_WIDTH'(1) << (SQUARE_WIDTH - 2);

    logic                    busy_reg;
    logic [STEP_WIDTH-1:0]   step_reg;
    logic [SQUARE_WIDTH-1:0] rem_reg, rem_next;
    logic [SQUARE_WIDTH-1:0] root_reg, root_next;
    logic [SQUARE_WIDTH-1:0] bit_reg;
    logic [SQUARE_WIDTH-1:0] trial;

    always_comb begin
        trial = root_reg + bit_reg;
        if (rem_reg >= trial) begin
            rem_next  = rem_reg - trial;
            root_next = (root_reg >> 1) + bit_reg;
        end else begin
            rem_next  = rem_reg;
            root_next = root_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + STEP_WIDTH'(1);
            if (step_reg == STEP_WIDTH'(STEP_COUNT - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= operand;
            root_reg <= '0;
            bit_reg  <= BIT_INIT;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            bit_reg  <= bit_reg >> 2;
        end
    end

    assign status.busy = busy_reg;
    assign status.root = root_reg[ROOT_WIDTH-1:0];

endmodule
